// ===== rtl/ebtp_pkg.sv =====
// Package for the EDF budget thread picker: payload types, table row type,
// command and run-state codes, and timing constants. No dependencies.
`default_nettype none

package ebtp_pkg;

    localparam int THREAD_COUNT_DEF = 64;

    localparam logic [63:0] NS_PER_MS = 64'd1000000;

    typedef enum logic [2:0] {
        CMD_DECLARE = 3'd0,
        CMD_STATUS  = 3'd1,
        CMD_SETTLE  = 3'd2,
        CMD_ENQUEUE = 3'd3,
        CMD_PICK    = 3'd4
    } command_t;

    localparam logic [1:0] RS_READY   = 2'd1;
    localparam logic [1:0] RS_RUNNING = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } state_t;

    // One input transaction
    typedef struct packed {
        logic [2:0]         command;
        logic [5:0]         thread_index;
        logic [47:0]        now_ms;
        logic [63:0]        time_ns;
        logic [15:0]        period_len;
        logic [15:0]        budget_len;
        logic [1:0]         run_state;
        logic signed [3:0]  pinned_core;
        logic signed [3:0]  running_core;
        logic               suspended;
        logic [2:0]         core;
    } req_t;

    // One result transaction
    typedef struct packed {
        logic       found;
        logic [5:0] chosen_index;
    } rsp_t;

    // One thread entry of the table
    typedef struct packed {
        logic [15:0] period;
        logic [15:0] budget;
        logic [47:0] deadline;
        logic [63:0] cpu_time;
        logic [63:0] period_start_cpu;
        logic [63:0] dispatch_time;
        logic [1:0]  run_state;
        logic [3:0]  pinned;
        logic [3:0]  running;
        logic        suspended;
    } row_t;

    localparam row_t ROW_RESET = '{
        period: 16'd0, budget: 16'd0, deadline: 48'd0, cpu_time: 64'd0,
        period_start_cpu: 64'd0, dispatch_time: 64'd0, run_state: 2'd0,
        pinned: 4'hF, running: 4'hF, suspended: 1'b0
    };

    // Table write request
    typedef struct packed {
        logic en;
        row_t row;
    } wr_req_t;

endpackage

`default_nettype wire

// ===== rtl/ebtp_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on ebtp_pkg for the payload types.
`default_nettype none

interface ebtp_req_if;
    logic           valid;
    logic           ready;
    ebtp_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ebtp_rsp_if;
    logic           valid;
    logic           ready;
    ebtp_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/edf_budget_thread_picker.sv =====
// Top level of the EDF budget thread picker; uses ebtp_pkg, ebtp_if and ebtp_table.
// A table command works only on its target row; a pick scans the table
// one row per cycle through the table memory's single read port. One transaction
// is in work at a time: the next request is taken only once the previous result
// has been loaded into the output register.
// Reset: rst_n clears control state and all table valid bits at once, so the table reads as reset.
`default_nettype none

module edf_budget_thread_picker #(
    parameter int THREAD_COUNT = ebtp_pkg::THREAD_COUNT_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    ebtp_req_if.sink    request,
    ebtp_rsp_if.source  response
);
    import ebtp_pkg::*;

    localparam int AW = $clog2(THREAD_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(THREAD_COUNT - 1);

    state_t state_reg, state_next;

    // Latched command
    req_t          q_reg;
    logic          t_ok_reg;
    logic [AW-1:0] t_addr_reg;

    // Issue stage
    logic          iss_active_reg;
    logic [AW-1:0] iss_cnt_reg;
    logic [AW-1:0] rd_addr;
    logic          iss_last;

    // Pipeline stages
    logic          a_v_reg, b_v_reg, c_v_reg, d_v_reg;
    logic          a_last_reg, b_last_reg, c_last_reg, d_last_reg;
    logic [AW-1:0] a_idx_reg, b_idx_reg, c_idx_reg, d_idx_reg;
    row_t          a_row;
    row_t          b_row_reg;
    logic          b_elig_reg, b_roll_reg, b_dge_reg;
    logic [63:0]   b_frag_reg;
    logic          c_elig_reg;
    logic [47:0]   c_dl_reg;
    logic [63:0]   c_used_reg, c_pst_reg, c_lim_reg;
    logic          d_cand_reg;
    logic [47:0]   d_dl_reg;

    // Best-so-far
    logic          have_reg, have_next;
    logic [AW-1:0] best_reg, best_next;
    logic [47:0]   best_dl_reg, best_dl_next;

    // Result
    logic          res_found_reg;
    logic [AW-1:0] res_idx_reg;
    logic          out_v_reg;
    rsp_t          out_reg;

    wr_req_t       wr;

    logic accept;
    assign accept = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);

    ebtp_table #(.THREAD_COUNT(THREAD_COUNT), .AW(AW)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (rd_addr),
        .rd_row  (a_row),
        .wr_addr (b_idx_reg),
        .wr      (wr)
    );

    // Choose read address: scan for pick, target entry otherwise
    always_comb
    begin
        if (q_reg.command == CMD_PICK)
        begin
            rd_addr  = iss_cnt_reg;
            iss_last = (iss_cnt_reg == LAST_ADDR);
        end
        else
        begin
            rd_addr  = t_addr_reg;
            iss_last = 1'b1;
        end
    end

    // Stage A: eligibility and expiry tests on the row just read
    logic        a_cur, a_elig, a_do_roll, a_ge, a_dge;
    logic [47:0] a_diff;
    logic [63:0] a_frag;
    always_comb
    begin
        a_cur  = t_ok_reg && (a_idx_reg == t_addr_reg);
        a_elig = (a_row.period != 16'd0)
              && !(!a_row.pinned[3] && (a_row.pinned[2:0] != q_reg.core))
              && !a_row.suspended
              && (a_cur || a_row.running[3])
              && ((a_row.run_state == RS_READY)
                  || (a_cur && a_row.run_state == RS_RUNNING));
        if (q_reg.command == CMD_PICK)
        begin
            a_do_roll = a_elig;
        end
        else
        begin
            a_do_roll = (q_reg.command == CMD_ENQUEUE) && t_ok_reg;
        end
        a_ge   = (q_reg.now_ms >= a_row.deadline);
        a_diff = q_reg.now_ms - a_row.deadline;
        a_dge  = (a_diff >= {32'd0, a_row.period});
        if (a_row.run_state == RS_RUNNING && a_row.dispatch_time != 64'd0
            && q_reg.time_ns > a_row.dispatch_time)
        begin
            a_frag = q_reg.time_ns - a_row.dispatch_time;
        end
        else
        begin
            a_frag = 64'd0;
        end
    end

    // Stage B: roll the period, apply the command, write back
    logic [48:0] b_sum;
    logic [47:0] b_dl;
    row_t        b_new;
    always_comb
    begin
        b_sum = b_dge_reg ? ({1'b0, q_reg.now_ms} + {33'd0, b_row_reg.period})
                          : ({1'b0, b_row_reg.deadline} + {33'd0, b_row_reg.period});
        b_dl  = b_sum[48] ? 48'hFFFF_FFFF_FFFF : b_sum[47:0];
        b_new = b_row_reg;
        wr.en = 1'b0;
        case (q_reg.command)
            CMD_DECLARE:
            begin
                b_new.period = q_reg.period_len;
                b_new.budget = q_reg.budget_len;
                wr.en        = t_ok_reg;
            end
            CMD_STATUS:
            begin
                b_new.run_state     = q_reg.run_state;
                b_new.pinned        = q_reg.pinned_core;
                b_new.running       = q_reg.running_core;
                b_new.suspended     = q_reg.suspended;
                b_new.dispatch_time = q_reg.time_ns;
                wr.en               = t_ok_reg;
            end
            CMD_SETTLE:
            begin
                b_new.cpu_time = q_reg.time_ns;
                wr.en          = t_ok_reg;
            end
            CMD_ENQUEUE, CMD_PICK:
            begin
                if (b_roll_reg)
                begin
                    b_new.deadline         = b_dl;
                    b_new.period_start_cpu = b_row_reg.cpu_time;
                end
                wr.en = b_roll_reg;
            end
            default:
            begin
                wr.en = 1'b0;
            end
        endcase
        wr.en  = wr.en && b_v_reg;
        wr.row = b_new;
    end

    // Stage D: keep the earliest deadline, lowest index on ties
    always_comb
    begin
        have_next    = have_reg;
        best_next    = best_reg;
        best_dl_next = best_dl_reg;
        if (d_v_reg && d_cand_reg && (!have_reg || d_dl_reg < best_dl_reg))
        begin
            have_next    = 1'b1;
            best_next    = d_idx_reg;
            best_dl_next = d_dl_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (d_v_reg && d_last_reg)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_v_reg || response.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iss_active_reg <= 1'b0;
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
            c_v_reg        <= 1'b0;
            d_v_reg        <= 1'b0;
            have_reg       <= 1'b0;
            out_v_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_v_reg   <= iss_active_reg;
            b_v_reg   <= a_v_reg;
            c_v_reg   <= b_v_reg;
            d_v_reg   <= c_v_reg;
            if (accept)
            begin
                iss_active_reg <= 1'b1;
                have_reg       <= 1'b0;
            end
            else
            begin
                if (iss_active_reg && iss_last)
                begin
                    iss_active_reg <= 1'b0;
                end
                have_reg <= have_next;
            end
            if (state_reg == ST_HOLD && (!out_v_reg || response.ready))
            begin
                out_v_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_reg       <= request.data;
            t_ok_reg    <= (32'(request.data.thread_index) < THREAD_COUNT);
            t_addr_reg  <= AW'(request.data.thread_index);
            iss_cnt_reg <= '0;
            best_reg    <= '0;
            best_dl_reg <= 48'd0;
        end
        else
        begin
            if (iss_active_reg)
            begin
                iss_cnt_reg <= iss_cnt_reg + 1'b1;
            end
            best_reg    <= best_next;
            best_dl_reg <= best_dl_next;
        end
        a_idx_reg  <= rd_addr;
        a_last_reg <= iss_last;

        b_row_reg  <= a_row;
        b_idx_reg  <= a_idx_reg;
        b_last_reg <= a_last_reg;
        b_elig_reg <= a_elig && (q_reg.command == CMD_PICK);
        b_roll_reg <= a_do_roll && (a_row.period != 16'd0) && a_ge;
        b_dge_reg  <= a_dge;
        b_frag_reg <= a_frag;

        c_idx_reg  <= b_idx_reg;
        c_last_reg <= b_last_reg;
        c_elig_reg <= b_elig_reg;
        c_dl_reg   <= b_new.deadline;
        c_used_reg <= b_row_reg.cpu_time + b_frag_reg;
        c_pst_reg  <= b_new.period_start_cpu;
        c_lim_reg  <= {48'd0, b_row_reg.budget} * NS_PER_MS;

        d_idx_reg  <= c_idx_reg;
        d_last_reg <= c_last_reg;
        d_cand_reg <= c_elig_reg && ((c_used_reg - c_pst_reg) < c_lim_reg);
        d_dl_reg   <= c_dl_reg;

        if (d_v_reg && d_last_reg)
        begin
            res_found_reg <= have_next;
            res_idx_reg   <= have_next ? best_next : '0;
        end
        if (state_reg == ST_HOLD && (!out_v_reg || response.ready))
        begin
            out_reg.found        <= res_found_reg;
            out_reg.chosen_index <= 6'(res_idx_reg);
        end
    end

    assign response.valid = out_v_reg;
    assign response.data  = out_reg;

`ifndef SYNTHESIS
    // Table writes happen only while a command is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> state_reg == ST_RUN)
        else $error("table write outside command");

    // Stage rows exist only while running
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_v_reg || b_v_reg || c_v_reg || d_v_reg) |-> state_reg == ST_RUN)
        else $error("pipeline busy outside run");

    // Last stage of the final row ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (d_v_reg && d_last_reg) |=> state_reg == ST_HOLD)
        else $error("run did not complete");

    // A found thread lies inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && response.data.found)
            |-> 32'(response.data.chosen_index) < THREAD_COUNT)
        else $error("chosen index out of table");
`endif

endmodule

`default_nettype wire

// ===== rtl/ebtp_table.sv =====
// Thread table: one synchronous memory of rows with a registered read port,
// plus per-entry valid bits so unwritten entries read as the reset row.
// Depends on ebtp_pkg.
`default_nettype none

module ebtp_table #(
    parameter int THREAD_COUNT = ebtp_pkg::THREAD_COUNT_DEF,
    parameter int AW           = $clog2(THREAD_COUNT)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [AW-1:0]    rd_addr,
    output ebtp_pkg::row_t        rd_row,
    input  wire logic [AW-1:0]    wr_addr,
    input  ebtp_pkg::wr_req_t     wr
);
    import ebtp_pkg::*;

    row_t                    mem [THREAD_COUNT];
    logic [THREAD_COUNT-1:0] vld_reg;
    row_t                    mem_q_reg;
    logic                    vld_q_reg;

    // Write port, and the registered read of the row at rd_addr
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr.row;
        end
        mem_q_reg <= mem[rd_addr];
    end

    // Mark written entries, and register the valid bit of the row read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_row = vld_q_reg ? mem_q_reg : ROW_RESET;

endmodule

`default_nettype wire

// ===== dv/tb_edf_checker.sv =====
// Checker for the EDF budget thread picker: watches the request and result
// channels, predicts each result from its own thread table, and counts mismatches.
// Depends on ebtp_pkg and the channel interfaces in ebtp_if.
`default_nettype none

module tb_edf_checker (
    input wire logic   clk,
    input wire logic   rst_n,
    ebtp_req_if        request,
    ebtp_rsp_if        response,
    output int         error_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import ebtp_pkg::*;

    localparam int THREADS = 64;
    localparam logic [47:0] DEADLINE_MAX = 48'hFFFF_FFFF_FFFF;

    row_t model_rows [THREADS];
    rsp_t expected_picks [$];
    int   mismatch_count;

    assign error_count   = mismatch_count;
    assign pending_count = expected_picks.size();

    function automatic logic [47:0] add_saturated(logic [47:0] a, logic [15:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {33'd0, b};
        return s[48] ? DEADLINE_MAX : s[47:0];
    endfunction

    // Advance an expired period: step or resync the deadline, refill budget
    task automatic roll_period(int i, logic [47:0] now);
        if (model_rows[i].period == 16'd0 || now < model_rows[i].deadline)
            return;
        if (now - model_rows[i].deadline >= {32'd0, model_rows[i].period})
            model_rows[i].deadline = add_saturated(now, model_rows[i].period);
        else
            model_rows[i].deadline = add_saturated(model_rows[i].deadline,
                                                   model_rows[i].period);
        model_rows[i].period_start_cpu = model_rows[i].cpu_time;
    endtask

    function automatic logic dispatchable(int i, logic is_cur, logic [2:0] core);
        row_t r;
        r = model_rows[i];
        if (!r.pinned[3] && r.pinned != {1'b0, core})
            return 1'b0;
        if (r.suspended)
            return 1'b0;
        if (!is_cur && !r.running[3])
            return 1'b0;
        return r.run_state == RS_READY || (is_cur && r.run_state == RS_RUNNING);
    endfunction

    // Apply one request to the table and compute its result
    task automatic apply_request(req_t q, output rsp_t res);
        int t;
        logic have;
        int best;
        logic [63:0] used;
        t = q.thread_index;
        res = '0;
        case (q.command)
            CMD_DECLARE:
            begin
                model_rows[t].period = q.period_len;
                model_rows[t].budget = q.budget_len;
            end
            CMD_STATUS:
            begin
                model_rows[t].run_state     = q.run_state;
                model_rows[t].pinned        = q.pinned_core;
                model_rows[t].running       = q.running_core;
                model_rows[t].suspended     = q.suspended;
                model_rows[t].dispatch_time = q.time_ns;
            end
            CMD_SETTLE:  model_rows[t].cpu_time = q.time_ns;
            CMD_ENQUEUE: roll_period(t, q.now_ms);
            CMD_PICK:
            begin
                have = 1'b0;
                best = 0;
                for (int i = 0; i < THREADS; i++)
                begin
                    if (model_rows[i].period == 16'd0)
                        continue;
                    if (!dispatchable(i, i == t, q.core))
                        continue;
                    roll_period(i, q.now_ms);
                    used = model_rows[i].cpu_time;
                    if (model_rows[i].run_state == RS_RUNNING
                        && model_rows[i].dispatch_time != 64'd0
                        && q.time_ns > model_rows[i].dispatch_time)
                        used += q.time_ns - model_rows[i].dispatch_time;
                    if (used - model_rows[i].period_start_cpu
                        >= {48'd0, model_rows[i].budget} * NS_PER_MS)
                        continue;
                    if (!have || model_rows[i].deadline < model_rows[best].deadline)
                    begin
                        have = 1'b1;
                        best = i;
                    end
                end
                if (have)
                begin
                    res.found = 1'b1;
                    res.chosen_index = best[5:0];
                end
            end
            default: ;
        endcase
    endtask

    // Predict on each request transaction, compare on each result transaction
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t res;
        rsp_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < THREADS; i++)
                model_rows[i] = ROW_RESET;
            expected_picks.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (request.valid && request.ready)
            begin
                apply_request(request.data, res);
                expected_picks.push_back(res);
            end
            if (response.valid && response.ready)
            begin
                if (expected_picks.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result found=%0d index=%0d",
                                 response.data.found, response.data.chosen_index);
                end
                else
                begin
                    exp_res = expected_picks.pop_front();
                    if (response.data.found !== exp_res.found
                        || response.data.chosen_index !== exp_res.chosen_index)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("result mismatch: expected found=%0d index=%0d, got found=%0d index=%0d",
                                     exp_res.found, exp_res.chosen_index,
                                     response.data.found, response.data.chosen_index);
                    end
                end
            end
        end
    end
endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Top of the EDF budget thread picker testbench: clock, reset, request stimulus
// with random gaps, result back-pressure, and the verdict. Uses tb_edf_checker.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ebtp_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   error_count;
    int   pending_count;
    logic hold_results = 1'b0;
    logic [47:0] uptime_ms = 48'd0;
    logic [63:0] uptime_ns = 64'd0;

    ebtp_req_if request ();
    ebtp_rsp_if response ();

    edf_budget_thread_picker uut (.clk(clk), .rst_n(rst_n),
                                  .request(request), .response(response));
    tb_edf_checker checker_inst (.clk(clk), .rst_n(rst_n), .request(request),
                                 .response(response), .error_count(error_count),
                                 .pending_count(pending_count));

    always #6 clk = ~clk;

    // Hand one transaction to the block, then idle for the gap given by the caller
    task automatic send(req_t q, int gap);
        request.data  <= q;
        request.valid <= 1'b1;
        @(posedge clk);
        while (!request.ready)
            @(posedge clk);
        @(negedge clk);
        if (gap > 0)
        begin
            request.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random request: small thread subset and clustered times to reach ties and rolls
    function automatic req_t random_request(logic [2:0] cmd);
        req_t q;
        q = '0;
        q.command      = cmd;
        q.thread_index = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 7));
        q.now_ms       = 48'(($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                         : {16'd0, uptime_ms + 48'($urandom_range(0, 40))});
        q.time_ns      = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                         : uptime_ns + 64'($urandom_range(0, 30_000_000));
        q.period_len   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
        q.budget_len   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        q.run_state    = ($urandom_range(0, 5) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
        q.pinned_core  = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF;
        q.running_core = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'hF;
        q.suspended    = ($urandom_range(0, 5) == 0);
        q.core         = 3'($urandom);
        return q;
    endfunction

    // Result side: random stalls, or a long hold while the sender keeps going
    initial
    begin
        response.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
            begin
                response.ready <= 1'b0;
                repeat (400) @(negedge clk);
                hold_results = 1'b0;
            end
            response.ready <= 1'b0;
            repeat ($urandom_range(0, 4)) @(negedge clk);
            response.ready <= 1'b1;
            @(posedge clk);
            while (!response.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        #80ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        req_t q;
        int gap;
        request.valid = 1'b0;
        request.data  = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: extremes, every command, ties, unknown codes, saturation
        q = '0;
        q.command = CMD_PICK;
        send(q, 0);
        for (int i = 0; i < 3; i++)
        begin
            q = '0;
            q.command = CMD_DECLARE; q.thread_index = 6'(i);
            q.period_len = 16'd10; q.budget_len = 16'd5;
            send(q, 0);
            q.command = CMD_STATUS; q.run_state = RS_READY;
            q.pinned_core = 4'hF; q.running_core = 4'hF;
            send(q, 0);
        end
        q.command = CMD_PICK; q.thread_index = 6'd63; q.now_ms = 48'd0; q.core = 3'd7;
        send(q, 1);
        q.command = CMD_ENQUEUE; q.thread_index = 6'd1; q.now_ms = 48'd5;
        send(q, 2);
        q.command = CMD_PICK; q.now_ms = 48'd100;
        send(q, 0);
        q = '0;
        q.command = CMD_DECLARE; q.thread_index = 6'd63;
        q.period_len = 16'hFFFF; q.budget_len = 16'hFFFF;
        send(q, 0);
        q.command = CMD_STATUS; q.run_state = RS_RUNNING; q.time_ns = 64'd1;
        q.pinned_core = 4'd7; q.running_core = 4'd7; q.suspended = 1'b0;
        send(q, 0);
        q.command = CMD_SETTLE; q.time_ns = '1;
        send(q, 0);
        q.command = CMD_PICK; q.now_ms = '1; q.time_ns = '1; q.core = 3'd7;
        send(q, 0);
        q.command = CMD_ENQUEUE; q.now_ms = '1;
        send(q, 0);
        q.command = 3'd5; send(q, 0);
        q.command = 3'd7; send(q, 0);
        q.command = CMD_STATUS; q.thread_index = 6'd2; q.run_state = 2'd3;
        q.suspended = 1'b1; q.pinned_core = 4'h8; q.running_core = 4'd0;
        send(q, 0);
        q.command = CMD_PICK; q.thread_index = 6'd0; q.now_ms = 48'd3; q.core = 3'd0;
        send(q, 0);

        // Stop offering, wait for the block to drain, then start random traffic
        request.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        @(negedge clk);

        // Random: mostly declare/status/pick mixes with a clock moving forward
        for (int n = 0; n < 1200; n++)
        begin
            uptime_ms += 48'($urandom_range(0, 4));
            uptime_ns += 64'($urandom_range(0, 4_000_000));
            case ($urandom_range(0, 9))
                0, 1:    q = random_request(CMD_DECLARE);
                2, 3:    q = random_request(CMD_STATUS);
                4:       q = random_request(CMD_SETTLE);
                5:       q = random_request(CMD_ENQUEUE);
                9:       q = random_request(3'($urandom));
                default: q = random_request(CMD_PICK);
            endcase
            if (n == 600)
                hold_results = 1'b1;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if ((n / 100) % 2 == 1)
                gap = 0;
            send(q, gap);
        end
        request.valid <= 1'b0;

        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

`default_nettype wire
